// ===== hdl/bpc_pkg.sv =====
// Package for the button press classifier: phase and event codes,
// register indexes, time width and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int TIME_BITS   = 32;
   localparam int NOW_BITS    = 32;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int EVENT_BITS  = 2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FIRST  = 3'd1,
      PH_GAP    = 3'd2,
      PH_SECOND = 3'd3,
      PH_WAIT   = 3'd4
   } phase_type;

   typedef enum logic [EVENT_BITS-1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_HOLD   = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_MIN_PRESS = 2'd0,
      REG_HOLD      = 2'd1,
      REG_GAP       = 2'd2
   } reg_index_type;

   localparam logic [CSR_BITS-1:0] MIN_PRESS_RESET = 16'd50;
   localparam logic [CSR_BITS-1:0] HOLD_RESET      = 16'd1000;
   localparam logic [CSR_BITS-1:0] GAP_RESET       = 16'd300;

   typedef struct packed {
      logic [CSR_BITS-1:0] min_press_ms;
      logic [CSR_BITS-1:0] hold_ms;
      logic [CSR_BITS-1:0] gap_ms;
   } cfg_type;

endpackage

// ===== hdl/bpc_csr.sv =====
// Configuration registers of the button press classifier.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_csr
   import bpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_write_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_MIN_PRESS: cfg_in.min_press_ms = csr_write_data;
            REG_HOLD:      cfg_in.hold_ms      = csr_write_data;
            REG_GAP:       cfg_in.gap_ms       = csr_write_data;
            default:       cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ms <= MIN_PRESS_RESET;
         cfg_ff.hold_ms      <= HOLD_RESET;
         cfg_ff.gap_ms       <= GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/bpc_fsm.sv =====
// Press classification state machine: phase and start time registers,
// elapsed time, threshold compares and event decode.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_fsm
   import bpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 button_level,
   input  logic [NOW_BITS-1:0]  now_ms,
   input  cfg_type              cfg,
   output event_type            event_code
);

   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic                 released;
   logic                 min_met, hold_met, gap_met;
   event_type            ev;

   assign now_t    = TIME_BITS'(now_ms);
   assign elapsed  = now_t - start_ff;
   assign released = button_level;
   assign min_met  = elapsed >= TIME_BITS'(cfg.min_press_ms);
   assign hold_met = elapsed >= TIME_BITS'(cfg.hold_ms);
   assign gap_met  = elapsed >= TIME_BITS'(cfg.gap_ms);

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      ev       = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (!released) begin
               phase_in = PH_FIRST;
               start_in = now_t;
            end
         end
         PH_FIRST: begin
            if (released) begin
               if (min_met) begin
                  phase_in = PH_GAP;
                  start_in = now_t;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (hold_met) begin
               phase_in = PH_WAIT;
               ev       = EV_HOLD;
            end
         end
         PH_GAP: begin
            if (!released) begin
               phase_in = PH_SECOND;
               start_in = now_t;
            end else if (gap_met) begin
               phase_in = PH_IDLE;
               ev       = EV_SINGLE;
            end
         end
         PH_SECOND: begin
            if (released) begin
               phase_in = PH_WAIT;
               ev       = EV_DOUBLE;
            end else if (hold_met) begin
               phase_in = PH_WAIT;
               ev       = EV_HOLD;
            end
         end
         default: begin
            if (released) begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
   end

   assign event_code = ev;

   a_hold_to_wait: assert property (@(posedge clock) disable iff (reset)
      (step_en && ev == EV_HOLD) |=> phase_ff == PH_WAIT)
      else $error("hold event did not enter wait release");

   a_single_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && ev == EV_SINGLE) |=> phase_ff == PH_IDLE)
      else $error("single event did not return to idle");

   a_double_from_second: assert property (@(posedge clock) disable iff (reset)
      (ev == EV_DOUBLE) |-> phase_ff == PH_SECOND && released)
      else $error("double event outside second press release");

endmodule

// ===== hdl/button_press_classifier.sv =====
// Button press classifier top level: request register, state machine step,
// result register. Throughput one request per cycle, limited only by
// result-side stall. Synchronous active-high reset: phase idle, start
// time 0, thresholds 50/1000/300 ms, pipeline empty. Depends on bpc_pkg,
// bpc_csr, bpc_fsm.
`timescale 1ns / 1ps

module button_press_classifier
   import bpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_button_level,
   input  logic [NOW_BITS-1:0]     req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [EVENT_BITS-1:0]   rsp_event_code,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_write_data
);

   cfg_type               cfg;
   logic                  adv;
   logic                  s1_load;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_level_ff;
   logic [NOW_BITS-1:0]   s1_now_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             rsp_event_ff;
   event_type             step_event;
   logic                  step_en;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !adv;
   assign s1_load   = req_valid && !req_stall;
   assign step_en   = s1_valid_ff && adv;

   assign s1_valid_in  = s1_load ? 1'b1 : (s1_valid_ff && !adv);
   assign rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;

   bpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bpc_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .button_level (s1_level_ff),
      .now_ms       (s1_now_ff),
      .cfg          (cfg),
      .event_code   (step_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_level_ff <= req_button_level;
         s1_now_ff   <= req_now_ms;
      end
      if (step_en) begin
         rsp_event_ff <= step_event;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff)
      else $error("request dropped while result stalled");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("state step without result");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_event_ff)))
      else $error("stalled result changed");

endmodule
